/* hw/rtl/epq_pkg.sv */
`timescale 1ns / 1ps

package epq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int JOB_W   = 16;
    localparam int KIND_W  = 4;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef struct packed {
        logic [JOB_W-1:0]  job;
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] time_key;
    } entry_t;

    typedef struct packed {
        logic              mode;
        logic [JOB_W-1:0]  job;
        logic [KIND_W-1:0] event_kind;
        logic [TIME_W-1:0] event_time;
    } in_t;

    typedef struct packed {
        logic [JOB_W-1:0]   front_job;
        logic [KIND_W-1:0]  front_kind;
        logic [TIME_W-1:0]  front_time;
        logic               front_valid;
        logic [COUNT_W-1:0] entry_count;
        status_t            status;
    } out_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t item;
    } ctrl_t;

endpackage

/* hw/rtl/epq_cell.sv */
`timescale 1ns / 1ps

module epq_cell (
    input  logic            clk,
    input  epq_pkg::ctrl_t  ctrl,
    input  logic            occupied,
    input  logic            left_keep,
    input  epq_pkg::entry_t left_entry,
    input  epq_pkg::entry_t right_entry,
    output logic            keep,
    output epq_pkg::entry_t entry,
    output epq_pkg::entry_t entry_next
);

    epq_pkg::entry_t entry_reg;

    // ties stay behind: held entry with equal time keeps its place
    assign keep  = occupied && (entry_reg.time_key <= ctrl.item.time_key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = ctrl.item;
            else
                entry_next = left_entry;
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hw/rtl/stable_event_priority_queue.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_data  (epq_pkg::in_t)
// out      output     out_valid / out_ready out_data (epq_pkg::out_t)
//
// One request per cycle while in_ready is high: every cell updates in the same cycle, the
// result sits in one output register and appears the cycle after acceptance.
// The per-cell time compare against the new event sets the cycle path.
// in_ready drops only while a result waits and out_ready is low.
// Reset empties the queue (count to zero); cell contents are not cleared.

module stable_event_priority_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  epq_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output epq_pkg::out_t  out_data
);

    localparam int D  = epq_pkg::DEPTH;
    localparam int CW = epq_pkg::CNT_W;

    logic [CW-1:0]   held_reg;
    logic [CW-1:0]   held_next;
    logic            out_valid_reg;
    epq_pkg::out_t   out_reg;
    epq_pkg::out_t   out_next;
    epq_pkg::ctrl_t  ctrl;
    epq_pkg::status_t status;

    logic            accept;
    logic            full;
    logic            empty;

    epq_pkg::entry_t cell_q [D];
    epq_pkg::entry_t cell_n [D];
    logic            keep   [D];
    logic            occ    [D];

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign full  = (held_reg == CW'(D));
    assign empty = (held_reg == '0);

    always_comb
    begin
        ctrl.item.job      = in_data.job;
        ctrl.item.kind     = in_data.event_kind;
        ctrl.item.time_key = in_data.event_time;
        ctrl.ins  = 1'b0;
        ctrl.rem  = 1'b0;
        status    = epq_pkg::ST_OK;
        held_next = held_reg;
        if (accept)
        begin
            if (in_data.mode == epq_pkg::MODE_INSERT)
            begin
                if (full)
                    status = epq_pkg::ST_FULL;
                else
                begin
                    ctrl.ins  = 1'b1;
                    held_next = held_reg + CW'(1);
                end
            end
            else
            begin
                if (empty)
                    status = epq_pkg::ST_EMPTY;
                else
                begin
                    ctrl.rem  = 1'b1;
                    held_next = held_reg - CW'(1);
                end
            end
        end
    end

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        assign occ[i] = (held_reg > CW'(i));

        if (i == 0)
        begin : g_head
            epq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ[i]),
                .left_keep  (1'b1),
                .left_entry (ctrl.item),
                .right_entry(cell_q[(i + 1) % D]),
                .keep       (keep[i]),
                .entry      (cell_q[i]),
                .entry_next (cell_n[i])
            );
        end
        else if (i == D - 1)
        begin : g_tail
            epq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ[i]),
                .left_keep  (keep[i - 1]),
                .left_entry (cell_q[i - 1]),
                .right_entry(cell_q[i]),
                .keep       (keep[i]),
                .entry      (cell_q[i]),
                .entry_next (cell_n[i])
            );
        end
        else
        begin : g_mid
            epq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ[i]),
                .left_keep  (keep[i - 1]),
                .left_entry (cell_q[i - 1]),
                .right_entry(cell_q[i + 1]),
                .keep       (keep[i]),
                .entry      (cell_q[i]),
                .entry_next (cell_n[i])
            );
        end
    end

    always_comb
    begin
        out_next.front_valid = (held_next != '0);
        out_next.front_job   = '0;
        out_next.front_kind  = '0;
        out_next.front_time  = '0;
        if (held_next != '0)
        begin
            out_next.front_job  = cell_n[0].job;
            out_next.front_kind = cell_n[0].kind;
            out_next.front_time = cell_n[0].time_key;
        end
        out_next.entry_count = epq_pkg::COUNT_W'(held_next);
        out_next.status      = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    epq_pkg::in_t   in_data;
    logic           out_valid;
    logic           out_ready = 1'b0;
    epq_pkg::out_t  out_data;

    // shadow copy of the queue contents, front at index 0
    epq_pkg::entry_t sched_slots [epq_pkg::DEPTH];
    int              sched_held;
    epq_pkg::out_t   pending_fronts [$];
    int              mismatches = 0;

    int burst_left       = 0;
    int ready_style      = 0;
    int ready_phase_left = 0;
    int ready_tick       = 0;

    stable_event_priority_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // applies one request to the shadow queue and returns the front it should report
    function automatic epq_pkg::out_t predict_front(input epq_pkg::in_t req);
        epq_pkg::out_t    res;
        epq_pkg::entry_t  fresh;
        epq_pkg::status_t st;
        int               pos;
        int               i;
        st = epq_pkg::ST_OK;
        if (req.mode == epq_pkg::MODE_INSERT)
        begin
            if (sched_held >= epq_pkg::DEPTH)
                st = epq_pkg::ST_FULL;
            else
            begin
                fresh.job      = req.job;
                fresh.kind     = req.event_kind;
                fresh.time_key = req.event_time;
                pos = 0;
                // ties go behind every held entry with the same time
                while (pos < sched_held && sched_slots[pos].time_key <= req.event_time)
                    pos++;
                for (i = sched_held; i > pos; i--)
                    sched_slots[i] = sched_slots[i-1];
                sched_slots[pos] = fresh;
                sched_held++;
            end
        end
        else
        begin
            if (sched_held == 0)
                st = epq_pkg::ST_EMPTY;
            else
            begin
                for (i = 0; i + 1 < sched_held; i++)
                    sched_slots[i] = sched_slots[i+1];
                sched_held--;
            end
        end
        res = '0;
        if (sched_held > 0)
        begin
            res.front_job   = sched_slots[0].job;
            res.front_kind  = sched_slots[0].kind;
            res.front_time  = sched_slots[0].time_key;
            res.front_valid = 1'b1;
        end
        res.entry_count = epq_pkg::COUNT_W'(sched_held);
        res.status      = st;
        return res;
    endfunction

    function automatic epq_pkg::in_t make_request(
        input epq_pkg::mode_t               mode,
        input logic [epq_pkg::JOB_W-1:0]    job,
        input logic [epq_pkg::KIND_W-1:0]   kind,
        input logic [epq_pkg::TIME_W-1:0]   tkey
    );
        epq_pkg::in_t req;
        req.mode       = mode;
        req.job        = job;
        req.event_kind = kind;
        req.event_time = tkey;
        return req;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input epq_pkg::in_t req);
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_fronts.push_back(predict_front(req));
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            in_valid <= 1'b0;
            in_data  <= 53'({$urandom, $urandom});
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        ready_tick <= ready_tick + 1;
        if (ready_phase_left == 0)
        begin
            ready_style      <= $urandom_range(0, 3);
            ready_phase_left <= $urandom_range(20, 80);
        end
        else
            ready_phase_left <= ready_phase_left - 1;
        case (ready_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((ready_tick % 16) < 11);
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        epq_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_fronts.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_fronts.pop_front();
                check_field("front_job",   want.front_job,   out_data.front_job);
                check_field("front_kind",  want.front_kind,  out_data.front_kind);
                check_field("front_time",  want.front_time,  out_data.front_time);
                check_field("front_valid", want.front_valid, out_data.front_valid);
                check_field("entry_count", want.entry_count, out_data.entry_count);
                check_field("status",      want.status,      out_data.status);
            end
        end
    end

    task automatic test_empty_removal();
        send_request(make_request(epq_pkg::MODE_REMOVE, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
        send_request(make_request(epq_pkg::MODE_REMOVE, 16'h0000, 4'h0, 32'h0000_0000));
    endtask

    task automatic test_tie_order();
        send_request(make_request(epq_pkg::MODE_INSERT, 16'd1, 4'h0, 32'd100));
        send_request(make_request(epq_pkg::MODE_INSERT, 16'd2, 4'hF, 32'd100));
        send_request(make_request(epq_pkg::MODE_INSERT, 16'd3, 4'h5, 32'd0));
        send_request(make_request(epq_pkg::MODE_INSERT, 16'd4, 4'hA, 32'd100));
        send_request(make_request(epq_pkg::MODE_INSERT, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
        send_request(make_request(epq_pkg::MODE_INSERT, 16'h0000, 4'h0, 32'd0));
        send_request(make_request(epq_pkg::MODE_REMOVE, 16'h0, 4'h0, 32'd0));
        send_request(make_request(epq_pkg::MODE_REMOVE, 16'h0, 4'h0, 32'd0));
    endtask

    task automatic test_full_drop();
        logic [epq_pkg::TIME_W-1:0] tkey;
        tkey = 32'd5000;
        // descending times push every new entry toward the front
        while (sched_held < epq_pkg::DEPTH)
        begin
            send_request(make_request(epq_pkg::MODE_INSERT, 16'($urandom), 4'($urandom),
                                      tkey));
            tkey = tkey - 32'd7;
        end
        send_request(make_request(epq_pkg::MODE_INSERT, 16'hAAAA, 4'h3, 32'd0));
        send_request(make_request(epq_pkg::MODE_INSERT, 16'h5555, 4'hC, 32'hFFFF_FFFF));
        send_request(make_request(epq_pkg::MODE_REMOVE, 16'h0, 4'h0, 32'd0));
        send_request(make_request(epq_pkg::MODE_INSERT, 16'h1234, 4'h9, 32'hFFFF_FFFF));
    endtask

    function automatic epq_pkg::in_t random_request(input int insert_pct);
        epq_pkg::in_t req;
        req.mode       = ($urandom_range(0, 99) < insert_pct) ? epq_pkg::MODE_INSERT
                                                              : epq_pkg::MODE_REMOVE;
        req.job        = 16'($urandom);
        req.event_kind = 4'($urandom);
        case ($urandom_range(0, 3))
            0:       req.event_time = $urandom_range(0, 7);
            1:       req.event_time = $urandom;
            2:       req.event_time = 32'hFFFF_FFF8 + $urandom_range(0, 7);
            default: req.event_time = $urandom_range(0, 1000);
        endcase
        return req;
    endfunction

    // phases lean toward inserts or removals (or neither) so the queue swings between full and empty
    task automatic test_random_traffic(input int num_requests);
        int phase_left;
        int insert_pct;
        phase_left = 0;
        insert_pct = 50;
        repeat (num_requests)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            send_request(random_request(insert_pct));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        sched_held = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_removal();
        test_tie_order();
        test_full_drop();
        test_random_traffic(400);

        in_valid <= 1'b0;
        while (pending_fronts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
